// File: design/hcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_pkg
// shared types, constants and mod 26 helpers for the 2x2 hill cipher
// ----------------------------------------------------------------------------
package hcf_pkg;

	localparam int unsigned HCF_ALPHA      = 26;
	localparam int unsigned HCF_CASE_GAP   = 32;
	localparam int unsigned HCF_LOWER_A    = 97;
	localparam int unsigned HCF_UPPER_A    = 65;
	localparam int unsigned HCF_UPPER_Z    = 90;

	localparam int unsigned HCF_CFG_IDX_W  = 3;
	localparam int unsigned HCF_CFG_DATA_W = 5;
	localparam int unsigned HCF_MID_DEPTH  = 2;
	localparam int unsigned HCF_OUT_DEPTH  = 2;

	typedef enum logic [HCF_CFG_IDX_W-1:0] {
		REG_KEY_00       = 3'd0,
		REG_KEY_01       = 3'd1,
		REG_KEY_10       = 3'd2,
		REG_KEY_11       = 3'd3,
		REG_DECRYPT_MODE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_in;
	} in_word_t;

	typedef struct packed {
		logic [6:0] char_out;
		logic       last_out;
		logic       bad_char;
		logic       key_error;
	} out_word_t;

	// a letter pair handed from the front to the back
	typedef struct packed {
		logic [4:0] p0;
		logic [4:0] p1;
		logic       bad;
		logic       last;
	} pair_t;

	// both result words of one pair
	typedef struct packed {
		out_word_t w1;
		out_word_t w0;
	} out_pair_t;

	typedef struct packed {
		logic [4:0] k00;
		logic [4:0] k01;
		logic [4:0] k10;
		logic [4:0] k11;
		logic       decrypt;
	} key_cfg_t;

	// mod 26 of an 11 bit value by restoring subtraction of 26 * 2^k
	function automatic logic [4:0] mod26(input logic [10:0] x);
		logic [10:0] r;
		r = x;
		for (int k = 6; k >= 0; k--) begin
			if (r >= (11'(HCF_ALPHA) << k)) begin
				r = r - (11'(HCF_ALPHA) << k);
			end
		end
		return r[4:0];
	endfunction

	// key register values above 25 wrap once
	function automatic logic [4:0] reduce26(input logic [4:0] k);
		return (k >= 5'(HCF_ALPHA)) ? (k - 5'(HCF_ALPHA)) : k;
	endfunction

	// additive inverse mod 26
	function automatic logic [4:0] neg26(input logic [4:0] m);
		return (m == 5'd0) ? 5'd0 : (5'(HCF_ALPHA) - m);
	endfunction

	// multiplicative inverse mod 26, zero where none exists
	function automatic logic [4:0] inv26(input logic [4:0] d);
		logic [4:0] r;
		unique case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [9:0] mul5(input logic [4:0] a, input logic [4:0] b);
		return {5'd0, a} * {5'd0, b};
	endfunction

endpackage

// File: design/hcf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_fifo
// small register queue with full and empty flags
// ----------------------------------------------------------------------------
module hcf_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : (p + PTR_W'(1));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill above depth");

	a_wr_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> !empty)
		else $error("queue empty after a lone write");

	a_rd_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> !full)
		else $error("queue full after a lone read");
`endif

endmodule

// File: design/hcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_front
// takes characters, folds case, classifies, and pairs letters up
// ----------------------------------------------------------------------------
module hcf_front
	import hcf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_word_t item,
	output logic     pair_wr,
	output pair_t    pair_word,
	input  logic     pair_full
);

	logic [4:0] held_letter_q;
	logic       held_valid_q;
	logic       held_bad_q;

	logic       accept;
	logic [7:0] folded;
	logic       is_letter;
	logic [4:0] letter;
	logic [7:0] offset;

	assign full   = pair_full;
	assign accept = push && !pair_full;

	always_comb begin
		folded = item.char_in;
		if (item.char_in >= 8'(HCF_UPPER_A) && item.char_in <= 8'(HCF_UPPER_Z)) begin
			folded = item.char_in + 8'(HCF_CASE_GAP);
		end
		is_letter = (folded >= 8'(HCF_LOWER_A)) && (folded < 8'(HCF_LOWER_A + HCF_ALPHA));
		offset    = folded - 8'(HCF_LOWER_A);
		// non-letters count as 'a'
		letter    = is_letter ? offset[4:0] : 5'd0;
	end

	always_comb begin
		pair_wr   = accept && (held_valid_q || item.last_in);
		pair_word = '0;
		if (held_valid_q) begin
			pair_word.p0   = held_letter_q;
			pair_word.p1   = letter;
			pair_word.bad  = held_bad_q || !is_letter;
			pair_word.last = item.last_in;
		end else begin
			// odd final letter, padded with 'a'
			pair_word.p0   = letter;
			pair_word.p1   = 5'd0;
			pair_word.bad  = !is_letter;
			pair_word.last = item.last_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q  <= 1'b0;
			held_bad_q    <= 1'b0;
		end else if (accept) begin
			if (held_valid_q || item.last_in) begin
				held_letter_q <= '0;
				held_valid_q  <= 1'b0;
				held_bad_q    <= 1'b0;
			end else begin
				held_letter_q <= letter;
				held_valid_q  <= 1'b1;
				held_bad_q    <= !is_letter;
			end
		end
	end

endmodule

// File: design/hcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_back
// key inversion and pair product pipeline, result queue and word split
// ----------------------------------------------------------------------------
module hcf_back
	import hcf_pkg::*;
#(
	parameter int unsigned OUT_DEPTH = HCF_OUT_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  key_cfg_t  cfg,
	input  pair_t     pair_word,
	input  logic      pair_empty,
	output logic      pair_pop,
	output out_word_t result,
	output logic      empty,
	input  logic      pop
);

	logic advance;
	logic out_full, out_empty, out_rd;
	out_pair_t out_wr_data, out_rd_data;
	logic half_q;

	// stage 1: reduced key and determinant products
	logic       v_s1;
	pair_t      pair_s1;
	logic [4:0] m00_s1, m01_s1, m10_s1, m11_s1;
	logic [9:0] pa_s1, pb_s1;
	// stage 2: determinant and its inverse
	logic       v_s2;
	pair_t      pair_s2;
	logic [4:0] m00_s2, m01_s2, m10_s2, m11_s2;
	logic [4:0] dinv_s2;
	logic       kerr_s2;
	// stage 3: adjugate times inverse
	logic       v_s3;
	pair_t      pair_s3;
	logic [4:0] m00_s3, m01_s3, m10_s3, m11_s3;
	logic [9:0] c00_s3, c01_s3, c10_s3, c11_s3;
	logic       kerr_s3;
	// stage 4: working matrix
	logic       v_s4;
	pair_t      pair_s4;
	logic [4:0] w00_s4, w01_s4, w10_s4, w11_s4;
	logic       kerr_s4;
	// stage 5: row vector times matrix
	logic        v_s5;
	pair_t       pair_s5;
	logic [10:0] sum0_s5, sum1_s5;
	logic        kerr_s5;

	logic [4:0] k00, k01, k10, k11;
	logic [4:0] det;
	logic [4:0] r0, r1;

	assign advance  = !v_s5 || !out_full;
	assign pair_pop = advance && !pair_empty;

	assign k00 = reduce26(cfg.k00);
	assign k01 = reduce26(cfg.k01);
	assign k10 = reduce26(cfg.k10);
	assign k11 = reduce26(cfg.k11);
	assign det = mod26(11'(pa_s1) + 11'(HCF_ALPHA * HCF_ALPHA) - 11'(pb_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= !pair_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pair_s1 <= pair_word;
			m00_s1  <= k00;
			m01_s1  <= k01;
			m10_s1  <= k10;
			m11_s1  <= k11;
			pa_s1   <= mul5(k00, k11);
			pb_s1   <= mul5(k01, k10);

			pair_s2 <= pair_s1;
			m00_s2  <= m00_s1;
			m01_s2  <= m01_s1;
			m10_s2  <= m10_s1;
			m11_s2  <= m11_s1;
			dinv_s2 <= inv26(det);
			kerr_s2 <= cfg.decrypt && (inv26(det) == 5'd0);

			pair_s3 <= pair_s2;
			m00_s3  <= m00_s2;
			m01_s3  <= m01_s2;
			m10_s3  <= m10_s2;
			m11_s3  <= m11_s2;
			c00_s3  <= mul5(m11_s2, dinv_s2);
			c01_s3  <= mul5(neg26(m01_s2), dinv_s2);
			c10_s3  <= mul5(neg26(m10_s2), dinv_s2);
			c11_s3  <= mul5(m00_s2, dinv_s2);
			kerr_s3 <= kerr_s2;

			pair_s4 <= pair_s3;
			w00_s4  <= cfg.decrypt ? mod26(11'(c00_s3)) : m00_s3;
			w01_s4  <= cfg.decrypt ? mod26(11'(c01_s3)) : m01_s3;
			w10_s4  <= cfg.decrypt ? mod26(11'(c10_s3)) : m10_s3;
			w11_s4  <= cfg.decrypt ? mod26(11'(c11_s3)) : m11_s3;
			kerr_s4 <= kerr_s3;

			pair_s5 <= pair_s4;
			sum0_s5 <= 11'(mul5(pair_s4.p0, w00_s4)) + 11'(mul5(pair_s4.p1, w10_s4));
			sum1_s5 <= 11'(mul5(pair_s4.p0, w01_s4)) + 11'(mul5(pair_s4.p1, w11_s4));
			kerr_s5 <= kerr_s4;
		end
	end

	// bad key forces both letters to 'a'
	assign r0 = kerr_s5 ? 5'd0 : mod26(sum0_s5);
	assign r1 = kerr_s5 ? 5'd0 : mod26(sum1_s5);

	always_comb begin
		out_wr_data.w0.char_out  = 7'(r0) + 7'(HCF_LOWER_A);
		out_wr_data.w0.last_out  = 1'b0;
		out_wr_data.w0.bad_char  = pair_s5.bad;
		out_wr_data.w0.key_error = kerr_s5;
		out_wr_data.w1.char_out  = 7'(r1) + 7'(HCF_LOWER_A);
		out_wr_data.w1.last_out  = pair_s5.last;
		out_wr_data.w1.bad_char  = pair_s5.bad;
		out_wr_data.w1.key_error = kerr_s5;
	end

	hcf_fifo #(
		.WIDTH ($bits(out_pair_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (v_s5),
		.wr_data (out_wr_data),
		.full    (out_full),
		.rd_en   (out_rd),
		.rd_data (out_rd_data),
		.empty   (out_empty)
	);

	// one queue entry holds both words of a pair
	assign empty  = out_empty;
	assign result = half_q ? out_rd_data.w1 : out_rd_data.w0;
	assign out_rd = pop && !out_empty && half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
		end else if (pop && !out_empty) begin
			half_q <= !half_q;
		end
	end

`ifndef SYNTH
	a_half_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> !out_empty)
		else $error("second word pending with no queue entry");

	a_kerr_only_decrypt: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && kerr_s5) |-> cfg.decrypt)
		else $error("key error raised in encrypt mode");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.char_out >= 7'(HCF_LOWER_A)
			&& result.char_out < 7'(HCF_LOWER_A + HCF_ALPHA)))
		else $error("result letter out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && out_full) |=> (v_s5 && $stable(sum0_s5) && $stable(sum1_s5)))
		else $error("last stage lost while result queue full");
`endif

endmodule

// File: design/hill_cipher_2x2_mod26.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26
// 2x2 hill cipher over the lower case alphabet, encrypt or decrypt
// ----------------------------------------------------------------------------
// usage
//   input queue: drive item and raise push; a word goes in at an edge with
//   push high and full low. one character per word, last_in on the final one.
//   result queue: while empty is low the oldest result word sits on result;
//   raise pop to take it. every letter pair gives two result words.
//   config: wr_en with wr_index / wr_data writes one key register in a cycle;
//   only write while nothing is in flight.
// throughput and pipeline
//   a closing letter's pair passes the pair queue, the five stage pair pipeline
//   and the result queue; its second word shows once the first is popped. one
//   character per cycle sustained while full is low, one result word per cycle
//   out while pop is held high and empty is low.
// reset
//   arst_n clears the held letter, the queues and the pipeline; the key comes
//   up as the identity matrix in encrypt mode.
// stalls
//   a held-off pop fills the result queue, then freezes the back end, then
//   the pair queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_mod26
	import hcf_pkg::*;
#(
	parameter int unsigned MID_DEPTH = HCF_MID_DEPTH,
	parameter int unsigned OUT_DEPTH = HCF_OUT_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input word queue
	input  logic                      push,
	output logic                      full,
	input  in_word_t                  item,
	// result word queue
	output logic                      empty,
	input  logic                      pop,
	output out_word_t                 result,
	// key register writes
	input  logic                      wr_en,
	input  logic [HCF_CFG_IDX_W-1:0]  wr_index,
	input  logic [HCF_CFG_DATA_W-1:0] wr_data
);

	key_cfg_t cfg_q;

	// front to back pair queue
	logic  pair_wr, pair_full, pair_pop, pair_empty;
	pair_t pair_in, pair_out;

	// key registers, identity key after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.k00     <= 5'd1;
			cfg_q.k01     <= 5'd0;
			cfg_q.k10     <= 5'd0;
			cfg_q.k11     <= 5'd1;
			cfg_q.decrypt <= 1'b0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_KEY_00:       cfg_q.k00     <= wr_data;
				REG_KEY_01:       cfg_q.k01     <= wr_data;
				REG_KEY_10:       cfg_q.k10     <= wr_data;
				REG_KEY_11:       cfg_q.k11     <= wr_data;
				REG_DECRYPT_MODE: cfg_q.decrypt <= wr_data[0];
				default:          ;  // index beyond the register list
			endcase
		end
	end

	// front: fold, classify and pair letters
	hcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.pair_wr   (pair_wr),
		.pair_word (pair_in),
		.pair_full (pair_full)
	);

	// short queue so front and back stall on their own
	hcf_fifo #(
		.WIDTH ($bits(pair_t)),
		.DEPTH (MID_DEPTH)
	) u_pair_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pair_wr),
		.wr_data (pair_in),
		.full    (pair_full),
		.rd_en   (pair_pop),
		.rd_data (pair_out),
		.empty   (pair_empty)
	);

	// back: matrix maths and result words
	hcf_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pair_word  (pair_out),
		.pair_empty (pair_empty),
		.pair_pop   (pair_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// File: sim/hill_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_check_pkg
// expected result words for the 2x2 hill cipher, worked out per character
// ----------------------------------------------------------------------------
package hill_check_pkg;

	import hcf_pkg::*;

	class cipher_tracker;

		// key registers and mode as last written
		logic [4:0] k00;
		logic [4:0] k01;
		logic [4:0] k10;
		logic [4:0] k11;
		logic       decrypt;

		// first letter of an open pair
		logic [4:0] held_letter;
		logic       held_valid;
		logic       held_bad;

		out_word_t   due_words[$];
		int unsigned fault_count;

		function new();
			k00         = 5'd1;
			k01         = 5'd0;
			k10         = 5'd0;
			k11         = 5'd1;
			decrypt     = 1'b0;
			held_letter = 5'd0;
			held_valid  = 1'b0;
			held_bad    = 1'b0;
			fault_count = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [4:0] v);
			case (idx)
				REG_KEY_00:       k00 = v;
				REG_KEY_01:       k01 = v;
				REG_KEY_10:       k10 = v;
				REG_KEY_11:       k11 = v;
				REG_DECRYPT_MODE: decrypt = v[0];
				default: ;
			endcase
		endfunction

		// search for the determinant's inverse, zero if it shares a factor with 26
		function int unsigned det_inverse(int unsigned d);
			for (int unsigned i = 1; i < HCF_ALPHA; i++) begin
				if ((d * i) % HCF_ALPHA == 1) return i;
			end
			return 0;
		endfunction

		// row vector times key (or inverse key), two words queued
		function void encipher_pair(int unsigned p0, int unsigned p1, logic bad, logic last);
			int unsigned m00, m01, m10, m11, det, dinv, r0, r1;
			int unsigned a, b, c, d;
			logic        kerr;
			out_word_t   w;
			m00  = k00 % HCF_ALPHA;
			m01  = k01 % HCF_ALPHA;
			m10  = k10 % HCF_ALPHA;
			m11  = k11 % HCF_ALPHA;
			kerr = 1'b0;
			if (decrypt) begin
				det  = (m00 * m11 + HCF_ALPHA * HCF_ALPHA - m01 * m10) % HCF_ALPHA;
				dinv = det_inverse(det);
				if (dinv == 0) begin
					kerr = 1'b1;
				end else begin
					a   = (m11 * dinv) % HCF_ALPHA;
					b   = (((HCF_ALPHA - m01) % HCF_ALPHA) * dinv) % HCF_ALPHA;
					c   = (((HCF_ALPHA - m10) % HCF_ALPHA) * dinv) % HCF_ALPHA;
					d   = (m00 * dinv) % HCF_ALPHA;
					m00 = a;
					m01 = b;
					m10 = c;
					m11 = d;
				end
			end
			if (kerr) begin
				r0 = 0;
				r1 = 0;
			end else begin
				r0 = (p0 * m00 + p1 * m10) % HCF_ALPHA;
				r1 = (p0 * m01 + p1 * m11) % HCF_ALPHA;
			end
			w.char_out  = 7'(r0 + HCF_LOWER_A);
			w.last_out  = 1'b0;
			w.bad_char  = bad;
			w.key_error = kerr;
			due_words.push_back(w);
			w.char_out  = 7'(r1 + HCF_LOWER_A);
			w.last_out  = last;
			due_words.push_back(w);
		endfunction

		// one accepted input word
		function void take_char(in_word_t w);
			int unsigned c, letter;
			logic        bad;
			c = w.char_in;
			if (c >= HCF_UPPER_A && c <= HCF_UPPER_Z) c = c + HCF_CASE_GAP;
			if (c >= HCF_LOWER_A && c < HCF_LOWER_A + HCF_ALPHA) begin
				letter = c - HCF_LOWER_A;
				bad    = 1'b0;
			end else begin
				letter = 0;
				bad    = 1'b1;
			end
			if (!held_valid) begin
				if (!w.last_in) begin
					held_letter = 5'(letter);
					held_bad    = bad;
					held_valid  = 1'b1;
					return;
				end
				// odd final letter, padded with a
				encipher_pair(letter, 0, bad, 1'b1);
			end else begin
				encipher_pair(held_letter, letter, held_bad | bad, w.last_in);
				held_letter = 5'd0;
				held_bad    = 1'b0;
				held_valid  = 1'b0;
			end
		endfunction

		// one accepted result word against the oldest expectation
		function void match_word(out_word_t got);
			out_word_t want;
			if (due_words.size() == 0) begin
				$error("result word with none expected: char_out %0d", got.char_out);
				fault_count++;
				return;
			end
			want = due_words.pop_front();
			if (got.char_out !== want.char_out) begin
				$error("char_out: expected %0d, got %0d", want.char_out, got.char_out);
				fault_count++;
			end
			if (got.last_out !== want.last_out) begin
				$error("last_out: expected %0d, got %0d", want.last_out, got.last_out);
				fault_count++;
			end
			if (got.bad_char !== want.bad_char) begin
				$error("bad_char: expected %0d, got %0d", want.bad_char, got.bad_char);
				fault_count++;
			end
			if (got.key_error !== want.key_error) begin
				$error("key_error: expected %0d, got %0d", want.key_error, got.key_error);
				fault_count++;
			end
		endfunction

		function int unsigned pending();
			return due_words.size();
		endfunction

	endclass

endpackage

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives characters into the hill cipher and checks every result word
// against a predicted stream, across key settings, modes and flow control
// ----------------------------------------------------------------------------
module tb;

	import hcf_pkg::*;
	import hill_check_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      push;
	logic                      full;
	in_word_t                  item;
	logic                      empty;
	logic                      pop;
	out_word_t                 result;
	logic                      wr_en;
	logic [HCF_CFG_IDX_W-1:0]  wr_index;
	logic [HCF_CFG_DATA_W-1:0] wr_data;

	// flow control knobs for the sender and the receiver
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_asked;
	int unsigned hold_served;

	cipher_tracker book;

	hill_cipher_2x2_mod26 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// a result word moves when pop is high and empty low at the edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			book.match_word(result);
		end
	end

	// receiver: random stalls, and on request one long hold-off so that the
	// result queue, the pipeline and then the input side back up
	initial begin : receiver
		int unsigned held_cycles;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_served) begin
				pop <= 1'b0;
				held_cycles = 0;
				while (held_cycles < 150) begin
					@(negedge clk);
					held_cycles++;
				end
				hold_served++;
			end else begin
				pop <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
			end
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

	// one character; random gaps first, then hold it until full is low at an edge
	task automatic send_char(input logic [7:0] c, input logic last);
		in_word_t w;
		w.char_in = c;
		w.last_in = last;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		book.take_char(w);
	endtask

	// stop offering, wait for every expected word, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [4:0] v);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(posedge clk);
		book.write_reg(idx, v);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// key changes only with the block idle
	task automatic load_key(input logic [4:0] k00, input logic [4:0] k01,
		input logic [4:0] k10, input logic [4:0] k11, input logic mode);
		drain();
		write_reg(REG_KEY_00, k00);
		write_reg(REG_KEY_01, k01);
		write_reg(REG_KEY_10, k10);
		write_reg(REG_KEY_11, k11);
		write_reg(REG_DECRYPT_MODE, {4'd0, mode});
	endtask

	// a message of letters in mixed case, a few odd bytes, last on the final one
	task automatic send_message(input int unsigned len, input int unsigned noise_pct);
		logic [7:0] c;
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(99) < noise_pct) begin
				c = 8'($urandom_range(255));
			end else begin
				c = 8'(($urandom_range(1) ? HCF_UPPER_A : HCF_LOWER_A) + $urandom_range(25));
			end
			send_char(c, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned len;
		book           = new();
		arst_n         = 1'b0;
		push           = 1'b0;
		item           = '0;
		wr_en          = 1'b0;
		wr_index       = '0;
		wr_data        = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_asked     = 0;
		hold_served    = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// identity key after reset: case folding and the alphabet's ends
		send_char(8'h41, 1'b0);   // A
		send_char(8'h7a, 1'b0);   // z
		send_char(8'h61, 1'b0);   // a
		send_char(8'h5a, 1'b0);   // Z
		// non-letters either side of both letter ranges, and the byte extremes
		send_char(8'h00, 1'b0);
		send_char(8'hff, 1'b0);
		send_char(8'h40, 1'b0);   // just below A
		send_char(8'h5b, 1'b0);   // just above Z
		send_char(8'h60, 1'b0);   // just below a
		send_char(8'h7b, 1'b0);   // just above z
		// odd final letter gets padded, then a pair closed by last
		send_char(8'h71, 1'b1);
		send_char(8'h62, 1'b0);
		send_char(8'h63, 1'b1);

		// invertible key, both directions
		load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b0);
		send_char(8'h68, 1'b0);
		send_char(8'h69, 1'b1);
		load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
		send_char(8'h68, 1'b0);
		send_char(8'h69, 1'b1);
		// singular key: error flag in decrypt, plain product in encrypt
		load_key(5'd2, 5'd4, 5'd6, 5'd8, 1'b1);
		send_char(8'h78, 1'b0);
		send_char(8'h79, 1'b1);
		load_key(5'd2, 5'd4, 5'd6, 5'd8, 1'b0);
		send_char(8'h78, 1'b0);
		send_char(8'h79, 1'b1);
		// key registers above 25 wrap before use
		load_key(5'd27, 5'd31, 5'd26, 5'd29, 1'b1);
		send_char(8'h6b, 1'b0);
		send_char(8'h6d, 1'b1);
		load_key(5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
		send_char(8'h7a, 1'b0);
		send_char(8'h5a, 1'b1);

		// random part: no idling, sender idle, receiver stalling, both lightly
		for (int phase = 0; phase < 4; phase++) begin
			for (int round = 0; round < 3; round++) begin
				load_key(5'($urandom_range(31)), 5'($urandom_range(31)),
					5'($urandom_range(31)), 5'($urandom_range(31)), 1'($urandom_range(1)));
				case (phase)
					0: begin
						send_idle_pct  = 0;
						recv_stall_pct = 0;
					end
					1: begin
						send_idle_pct  = 80;
						recv_stall_pct = 0;
					end
					2: begin
						send_idle_pct  = 0;
						recv_stall_pct = 80;
					end
					default: begin
						send_idle_pct  = 15;
						recv_stall_pct = 15;
					end
				endcase
				// long receiver hold-off while the sender keeps going
				if (phase == 0 && round == 0) hold_asked++;
				sent = 0;
				while (sent < 125) begin
					len = $urandom_range(1, 14);
					if ($urandom_range(9) == 0) begin
						// broken stream: any byte, last at random
						for (int unsigned i = 0; i < len; i++) begin
							send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
						end
					end else begin
						send_message(len, 8);
					end
					sent = sent + len;
				end
			end
		end

		drain();
		if (book.fault_count == 0 && book.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: sim.f
design/hcf_pkg.sv
design/hcf_fifo.sv
design/hcf_front.sv
design/hcf_back.sv
design/hill_cipher_2x2_mod26.sv
sim/hill_check_pkg.sv
sim/tb.sv
